// ===== design/tpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared widths and payload types for the triangle perimeter/area pipeline.
// ----------------------------------------------------------------------------
package tpa_pkg;

  localparam int COORD_BITS    = 16;
  localparam int FRAC_BITS     = 8;
  localparam int PERIM_BITS    = 27;
  localparam int AREA_BITS     = 47;

  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int SQ_BITS       = 2 * COORD_BITS;
  localparam int SUM_BITS      = SQ_BITS + 1;
  localparam int SIDE_RAD_BITS = ((SUM_BITS + 2 * FRAC_BITS + 1) / 2) * 2;
  localparam int SIDE_PAD_BITS = SIDE_RAD_BITS - SUM_BITS - 2 * FRAC_BITS;
  localparam int LEN_BITS      = SIDE_RAD_BITS / 2;
  localparam int FACT_BITS     = LEN_BITS + 2;
  localparam int HALF_BITS     = FACT_BITS;
  localparam int PAIR_BITS     = 2 * FACT_BITS;
  localparam int PROD_BITS     = 4 * FACT_BITS;
  localparam int ROOT_BITS     = PROD_BITS / 2;
  localparam int QUOT_BITS     = ROOT_BITS - 2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
  } tpa_in_t;

  typedef struct packed {
    logic [PERIM_BITS-1:0] perimeter;
    logic [AREA_BITS-1:0]  area;
  } tpa_out_t;

endpackage

// ===== design/tpa_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_isqrt
// Pipelined floor square root, one root bit per stage, with a sideband that
// travels alongside. One operand per cycle is accepted.
// ----------------------------------------------------------------------------
module tpa_isqrt #(
  parameter int RAD_W = 50,
  parameter int SB_W  = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [RAD_W-1:0]     in_rad,
  input  logic [SB_W-1:0]      in_sb,
  output logic                 out_valid,
  output logic [RAD_W/2-1:0]   out_root,
  output logic [SB_W-1:0]      out_sb
);

  localparam int N = RAD_W / 2;

  logic             v_r   [N];
  logic [N+1:0]     rem_r [N];
  logic [N-1:0]     q_r   [N];
  logic [RAD_W-1:0] x_r   [N];
  logic [SB_W-1:0]  sb_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic             v_i;
    logic [N+1:0]     rem_i;
    logic [N-1:0]     q_i;
    logic [RAD_W-1:0] x_i;
    logic [SB_W-1:0]  sb_i;
    logic [N+1:0]     rem_s;
    logic [N+1:0]     trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_i   = in_valid;
      assign rem_i = '0;
      assign q_i   = '0;
      assign x_i   = in_rad;
      assign sb_i  = in_sb;
    end else begin : g_next
      assign v_i   = v_r[k-1];
      assign rem_i = rem_r[k-1];
      assign q_i   = q_r[k-1];
      assign x_i   = x_r[k-1];
      assign sb_i  = sb_r[k-1];
    end

    // remainder stays below 2^N on entry, so the top two bits are free
    assign rem_s = {rem_i[N-1:0], x_i[RAD_W-1:RAD_W-2]};
    assign trial = {q_i, 2'b01};
    assign ge    = (rem_s >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? (rem_s - trial) : rem_s;
      q_r[k]   <= {q_i[N-2:0], ge};
      x_r[k]   <= x_i << 2;
      sb_r[k]  <= sb_i;
    end
  end

  assign out_valid = v_r[N-1];
  assign out_root  = q_r[N-1];
  assign out_sb    = sb_r[N-1];

endmodule

// ===== design/tpa_sides.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_sides
// Side lengths: coordinate differences, squares, sum, then a square-root
// pipeline per side giving lengths with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module tpa_sides (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  tpa_pkg::tpa_in_t         in_data,
  output logic                     out_valid,
  output logic [tpa_pkg::LEN_BITS-1:0] out_la,
  output logic [tpa_pkg::LEN_BITS-1:0] out_lb,
  output logic [tpa_pkg::LEN_BITS-1:0] out_lc
);

  import tpa_pkg::*;

  logic signed [COORD_BITS-1:0] px [3];
  logic signed [COORD_BITS-1:0] py [3];

  logic                  v1_r, v2_r, v3_r;
  logic [COORD_BITS-1:0] dx_r  [3];
  logic [COORD_BITS-1:0] dy_r  [3];
  logic [SQ_BITS-1:0]    sqx_r [3];
  logic [SQ_BITS-1:0]    sqy_r [3];
  logic [SUM_BITS-1:0]   sum_r [3];
  logic                  lv    [3];
  logic [LEN_BITS-1:0]   len   [3];

  assign px[0] = in_data.ax;
  assign py[0] = in_data.ay;
  assign px[1] = in_data.bx;
  assign py[1] = in_data.by;
  assign px[2] = in_data.cx;
  assign py[2] = in_data.cy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // side i joins vertices (i+1)%3 and (i+2)%3
  for (genvar i = 0; i < 3; i++) begin : g_side
    logic signed [DIFF_BITS-1:0] ddx, ddy;
    logic [DIFF_BITS-1:0]        mx, my;

    assign ddx = DIFF_BITS'(px[(i+2)%3]) - DIFF_BITS'(px[(i+1)%3]);
    assign ddy = DIFF_BITS'(py[(i+2)%3]) - DIFF_BITS'(py[(i+1)%3]);
    assign mx  = ddx[DIFF_BITS-1] ? DIFF_BITS'(-ddx) : DIFF_BITS'(ddx);
    assign my  = ddy[DIFF_BITS-1] ? DIFF_BITS'(-ddy) : DIFF_BITS'(ddy);

    always_ff @(posedge clk) begin
      dx_r[i]  <= mx[COORD_BITS-1:0];
      dy_r[i]  <= my[COORD_BITS-1:0];
      sqx_r[i] <= dx_r[i] * dx_r[i];
      sqy_r[i] <= dy_r[i] * dy_r[i];
      sum_r[i] <= SUM_BITS'(sqx_r[i]) + SUM_BITS'(sqy_r[i]);
    end

    tpa_isqrt #(
      .RAD_W (SIDE_RAD_BITS),
      .SB_W  (1)
    ) u_root (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v3_r),
      .in_rad    ({{SIDE_PAD_BITS{1'b0}}, sum_r[i], {(2*FRAC_BITS){1'b0}}}),
      .in_sb     (1'b0),
      .out_valid (lv[i]),
      .out_root  (len[i]),
      .out_sb    ()
    );
  end

  assign out_valid = lv[0] & lv[1] & lv[2];
  assign out_la    = len[0];
  assign out_lb    = len[1];
  assign out_lc    = len[2];

endmodule

// ===== design/tpa_heron.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_heron
// Perimeter and Heron product P = s(s-2a)(s-2b)(s-2c), zero when P <= 0.
// Four stages: factors, pair products, split partial products, final sum.
// ----------------------------------------------------------------------------
module tpa_heron (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [tpa_pkg::LEN_BITS-1:0]  in_la,
  input  logic [tpa_pkg::LEN_BITS-1:0]  in_lb,
  input  logic [tpa_pkg::LEN_BITS-1:0]  in_lc,
  output logic                          out_valid,
  output logic [tpa_pkg::PERIM_BITS-1:0] out_perim,
  output logic [tpa_pkg::PROD_BITS-1:0] out_prod
);

  import tpa_pkg::*;

  localparam int SF = FACT_BITS + 1;

  logic [FACT_BITS-1:0]    s;
  logic signed [SF-1:0]    f1, f2, f3;
  logic [FACT_BITS-1:0]    m1, m2, m3;
  logic                    kill;

  logic                    v1_r, v2_r, v3_r, v4_r;
  logic                    k1_r, k2_r, k3_r;
  logic [PERIM_BITS-1:0]   s1_r, s2_r, s3_r, s4_r;
  logic [FACT_BITS-1:0]    f_r [4];
  logic [PAIR_BITS-1:0]    m01_r, m23_r;
  logic [PAIR_BITS-1:0]    hh_r, hl_r, lh_r, ll_r;
  logic [PROD_BITS-1:0]    p_r;
  logic [PAIR_BITS:0]      mid;

  assign s  = FACT_BITS'(in_la) + FACT_BITS'(in_lb) + FACT_BITS'(in_lc);
  assign f1 = $signed({1'b0, s}) - $signed({2'b00, in_la, 1'b0});
  assign f2 = $signed({1'b0, s}) - $signed({2'b00, in_lb, 1'b0});
  assign f3 = $signed({1'b0, s}) - $signed({2'b00, in_lc, 1'b0});
  assign m1 = f1[SF-1] ? FACT_BITS'(-f1) : FACT_BITS'(f1);
  assign m2 = f2[SF-1] ? FACT_BITS'(-f2) : FACT_BITS'(f2);
  assign m3 = f3[SF-1] ? FACT_BITS'(-f3) : FACT_BITS'(f3);
  // drop the area on any zero factor or a negative product
  assign kill = (s == '0) || (f1 == '0) || (f2 == '0) || (f3 == '0) ||
                (f1[SF-1] ^ f2[SF-1] ^ f3[SF-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign mid = (PAIR_BITS+1)'(hl_r) + (PAIR_BITS+1)'(lh_r);

  always_ff @(posedge clk) begin
    s1_r   <= PERIM_BITS'(s);
    k1_r   <= kill;
    f_r[0] <= s;
    f_r[1] <= m1;
    f_r[2] <= m2;
    f_r[3] <= m3;

    s2_r  <= s1_r;
    k2_r  <= k1_r;
    m01_r <= f_r[0] * f_r[1];
    m23_r <= f_r[2] * f_r[3];

    s3_r <= s2_r;
    k3_r <= k2_r;
    hh_r <= m01_r[PAIR_BITS-1:HALF_BITS] * m23_r[PAIR_BITS-1:HALF_BITS];
    hl_r <= m01_r[PAIR_BITS-1:HALF_BITS] * m23_r[HALF_BITS-1:0];
    lh_r <= m01_r[HALF_BITS-1:0] * m23_r[PAIR_BITS-1:HALF_BITS];
    ll_r <= m01_r[HALF_BITS-1:0] * m23_r[HALF_BITS-1:0];

    s4_r <= s3_r;
    if (k3_r) begin
      p_r <= '0;
    end else begin
      p_r <= {hh_r, {PAIR_BITS{1'b0}}}
           + {{(PROD_BITS-PAIR_BITS-1-HALF_BITS){1'b0}}, mid, {HALF_BITS{1'b0}}}
           + {{(PROD_BITS-PAIR_BITS){1'b0}}, ll_r};
    end
  end

  assign out_valid = v4_r;
  assign out_perim = s4_r;
  assign out_prod  = p_r;

endmodule

// ===== design/triangle_perimeter_area.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_perimeter_area
// Perimeter and Heron area of a triangle given by three integer vertices.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_data (six signed 16-bit coordinates) and pulse start.
//   busy is always low, so a transfer happens on every cycle start is high;
//   one triangle per cycle sustained.
//   Output: out_valid is high for one cycle with out_data (perimeter in
//   1/256 units, area in 1/65536 units). Results leave in input order.
//   From start to out_valid: registered differences, squares and sums,
//   25 side-root stages, 4 product stages, 54 area-root stages (one root
//   bit per stage) and the output register.
//   Reset (rst_n low, synchronous) clears all valid bits; items in flight
//   are dropped. The receiver has no backpressure: results must be taken
//   in the cycle they appear.
// ----------------------------------------------------------------------------
module triangle_perimeter_area (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tpa_pkg::tpa_in_t  in_data,
  output logic              out_valid,
  output tpa_pkg::tpa_out_t out_data
);

  import tpa_pkg::*;

  logic                  side_v;
  logic [LEN_BITS-1:0]   la, lb, lc;
  logic                  her_v;
  logic [PERIM_BITS-1:0] her_perim;
  logic [PROD_BITS-1:0]  her_prod;
  logic                  root_v;
  logic [ROOT_BITS-1:0]  root;
  logic [PERIM_BITS-1:0] root_perim;
  logic [QUOT_BITS-1:0]  quot;

  logic                  out_valid_r;
  tpa_out_t              out_data_r;

  assign busy = 1'b0;

  tpa_sides u_sides (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_data   (in_data),
    .out_valid (side_v),
    .out_la    (la),
    .out_lb    (lb),
    .out_lc    (lc)
  );

  tpa_heron u_heron (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (side_v),
    .in_la     (la),
    .in_lb     (lb),
    .in_lc     (lc),
    .out_valid (her_v),
    .out_perim (her_perim),
    .out_prod  (her_prod)
  );

  tpa_isqrt #(
    .RAD_W (PROD_BITS),
    .SB_W  (PERIM_BITS)
  ) u_area_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (her_v),
    .in_rad    (her_prod),
    .in_sb     (her_perim),
    .out_valid (root_v),
    .out_root  (root),
    .out_sb    (root_perim)
  );

  assign quot = root[ROOT_BITS-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= root_v;
    end
  end

  // saturate the area to the output width
  always_ff @(posedge clk) begin
    out_data_r.perimeter <= root_perim;
    if (quot[QUOT_BITS-1:AREA_BITS] != '0) begin
      out_data_r.area <= '1;
    end else begin
      out_data_r.area <= quot[AREA_BITS-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
